// ===== rtl/core/rea_pkg.sv =====
// rea_pkg: shared types, register codes, event codes and phase tables
// for the rotary encoder block; no dependencies
`default_nettype none

package rea_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [31:0] DEBOUNCE_TIME_MS = 32'd5;

    localparam logic signed [15:0] MIN_VALUE_RST   = 16'sd0;
    localparam logic signed [15:0] MAX_VALUE_RST   = 16'sd127;
    localparam logic [9:0]         STEP_SIZE_RST   = 10'd1;
    localparam logic [15:0]        MEDIUM_MS_RST   = 16'd100;
    localparam logic [15:0]        FAST_MS_RST     = 16'd40;
    localparam logic [3:0]         MEDIUM_MULT_RST = 4'd2;
    localparam logic [3:0]         FAST_MULT_RST   = 4'd3;
    localparam logic [3:0]         MEDIUM_MULT_DEF = 4'd2;
    localparam logic [3:0]         FAST_MULT_DEF   = 4'd4;

    localparam logic [1:0] PHASE_IDLE = 2'd3;

    typedef enum logic [2:0] {
        REG_MIN_VALUE   = 3'd0,
        REG_MAX_VALUE   = 3'd1,
        REG_WRAP_ENABLE = 3'd2,
        REG_STEP_SIZE   = 3'd3,
        REG_MEDIUM_MS   = 3'd4,
        REG_FAST_MS     = 3'd5,
        REG_MEDIUM_MULT = 3'd6,
        REG_FAST_MULT   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_INC  = 2'd1,
        ROT_DEC  = 2'd2
    } t_rot_event;

    typedef enum logic [1:0] {
        BTN_NONE  = 2'd0,
        BTN_START = 2'd1,
        BTN_END   = 2'd2
    } t_btn_event;

    typedef struct packed {
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic               wrap_enable;
        logic [9:0]         step_size;
        logic [15:0]        accel_medium_ms;
        logic [15:0]        accel_fast_ms;
        logic [3:0]         medium_multiplier;
        logic [3:0]         fast_multiplier;
    } t_cfg;

    typedef struct packed {
        logic               min_we;
        logic               max_we;
        logic signed [15:0] bound;
    } t_bound_wr;

    typedef struct packed {
        logic fire;
        logic up;
    } t_detent;

    typedef struct packed {
        logic        quad_a;
        logic        quad_b;
        logic        switch_level;
        logic [31:0] now_ms;
    } t_sample;

    // 0 none, 1 forward, 3 backward
    localparam logic [1:0] PHASE_TABLE [16] = '{
        2'd0, 2'd1, 2'd3, 2'd0,
        2'd3, 2'd0, 2'd0, 2'd1,
        2'd1, 2'd0, 2'd0, 2'd3,
        2'd0, 2'd3, 2'd1, 2'd0
    };

    localparam logic [1:0] RING_POS [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    // quarter step delta, skipped phases recovered from ring distance
    function automatic logic signed [2:0] phase_delta(input logic [1:0] last,
                                                      input logic [1:0] cur);
        logic [1:0]        t;
        logic signed [3:0] diff;
        logic signed [2:0] d;
        t    = PHASE_TABLE[{last, cur}];
        diff = $signed({2'b00, RING_POS[cur]}) - $signed({2'b00, RING_POS[last]});
        if (diff > 4'sd2) begin
            diff = diff - 4'sd4;
        end
        if (diff < -4'sd2) begin
            diff = diff + 4'sd4;
        end
        case (t)
            2'd1:    d = 3'sd1;
            2'd3:    d = -3'sd1;
            default: d = diff[2:0];
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rea_cfg_regs.sv =====
// rea_cfg_regs: configuration register file with zero-value substitution
// depends on rea_pkg
`default_nettype none

module rea_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_we,
    input  wire logic [rea_pkg::CFG_IDX_W-1:0]     i_idx,
    input  wire logic [rea_pkg::CFG_DATA_W-1:0]    i_wdata,
    output rea_pkg::t_cfg                          o_cfg,
    output rea_pkg::t_bound_wr                     o_bound_wr
);

    rea_pkg::t_cfg    r_cfg;
    rea_pkg::t_reg_idx idx;

    assign idx = rea_pkg::t_reg_idx'(i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_value         <= rea_pkg::MIN_VALUE_RST;
            r_cfg.max_value         <= rea_pkg::MAX_VALUE_RST;
            r_cfg.wrap_enable       <= 1'b0;
            r_cfg.step_size         <= rea_pkg::STEP_SIZE_RST;
            r_cfg.accel_medium_ms   <= rea_pkg::MEDIUM_MS_RST;
            r_cfg.accel_fast_ms     <= rea_pkg::FAST_MS_RST;
            r_cfg.medium_multiplier <= rea_pkg::MEDIUM_MULT_RST;
            r_cfg.fast_multiplier   <= rea_pkg::FAST_MULT_RST;
        end else if (i_we) begin
            unique case (idx)
                rea_pkg::REG_MIN_VALUE: r_cfg.min_value <= $signed(i_wdata);
                rea_pkg::REG_MAX_VALUE: r_cfg.max_value <= $signed(i_wdata);
                rea_pkg::REG_WRAP_ENABLE: r_cfg.wrap_enable <= i_wdata[0];
                rea_pkg::REG_STEP_SIZE: begin
                    r_cfg.step_size <= (i_wdata[9:0] == 10'd0) ? 10'd1 : i_wdata[9:0];
                end
                rea_pkg::REG_MEDIUM_MS: begin
                    r_cfg.accel_medium_ms <= (i_wdata == 16'd0) ? 16'd1 : i_wdata;
                end
                rea_pkg::REG_FAST_MS: begin
                    r_cfg.accel_fast_ms <= (i_wdata == 16'd0) ? 16'd1 : i_wdata;
                end
                rea_pkg::REG_MEDIUM_MULT: begin
                    r_cfg.medium_multiplier <= (i_wdata[3:0] == 4'd0) ?
                        rea_pkg::MEDIUM_MULT_DEF : i_wdata[3:0];
                end
                rea_pkg::REG_FAST_MULT: begin
                    r_cfg.fast_multiplier <= (i_wdata[3:0] == 4'd0) ?
                        rea_pkg::FAST_MULT_DEF : i_wdata[3:0];
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

    always_comb begin
        o_bound_wr.min_we = i_we && (idx == rea_pkg::REG_MIN_VALUE);
        o_bound_wr.max_we = i_we && (idx == rea_pkg::REG_MAX_VALUE);
        o_bound_wr.bound  = $signed(i_wdata);
    end

endmodule

`default_nettype wire

// ===== rtl/core/rea_quad_dec.sv =====
// rea_quad_dec: quadrature phase decoder and quarter-step accumulator
// depends on rea_pkg
`default_nettype none

module rea_quad_dec (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_quad_a,
    input  wire logic       i_quad_b,
    output rea_pkg::t_detent o_detent
);

    logic [1:0]        r_last_phase;
    logic signed [2:0] r_step_accum;
    logic signed [2:0] n_step_accum;
    logic [1:0]        cur;
    logic              moved;
    logic signed [2:0] delta;
    logic signed [3:0] sum;
    logic signed [3:0] sum_adj;

    always_comb begin
        cur     = {i_quad_a, i_quad_b};
        moved   = (cur != r_last_phase);
        delta   = rea_pkg::phase_delta(r_last_phase, cur);
        sum     = $signed({r_step_accum[2], r_step_accum}) + $signed({delta[2], delta});
        o_detent.fire = moved && ((sum >= 4'sd4) || (sum <= -4'sd4));
        o_detent.up   = !sum[3];
        if (o_detent.fire) begin
            sum_adj = o_detent.up ? (sum - 4'sd4) : (sum + 4'sd4);
        end else begin
            sum_adj = sum;
        end
        n_step_accum = sum_adj[2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase <= rea_pkg::PHASE_IDLE;
            r_step_accum <= 3'sd0;
        end else if (i_en && moved) begin
            r_last_phase <= cur;
            r_step_accum <= n_step_accum;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rea_value.sv =====
// rea_value: detent acceleration, counter update and bound handling
// depends on rea_pkg
`default_nettype none

module rea_value (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  rea_pkg::t_detent       i_detent,
    input  wire logic [31:0]       i_now_ms,
    input  rea_pkg::t_cfg          i_cfg,
    input  rea_pkg::t_bound_wr     i_bound_wr,
    output rea_pkg::t_rot_event    o_rot_event,
    output logic signed [15:0]     o_value
);

    logic signed [15:0] r_count;
    logic signed [15:0] n_count;
    logic [31:0]        r_last_detent;
    logic [31:0]        interval;
    logic [3:0]         mult;
    logic [13:0]        prod;
    logic signed [17:0] sum;
    logic signed [17:0] max_ext;
    logic signed [17:0] min_ext;
    logic signed [15:0] det_val;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_val;

    always_comb begin
        interval = (r_last_detent == 32'd0) ? 32'd0 : (i_now_ms - r_last_detent);
        if (interval == 32'd0) begin
            mult = 4'd1;
        end else if (interval <= {16'd0, i_cfg.accel_fast_ms}) begin
            mult = i_cfg.fast_multiplier;
        end else if (interval <= {16'd0, i_cfg.accel_medium_ms}) begin
            mult = i_cfg.medium_multiplier;
        end else begin
            mult = 4'd1;
        end
        prod    = {4'd0, i_cfg.step_size} * {10'd0, mult};
        max_ext = {{2{i_cfg.max_value[15]}}, i_cfg.max_value};
        min_ext = {{2{i_cfg.min_value[15]}}, i_cfg.min_value};
        if (i_detent.up) begin
            sum = $signed({{2{r_count[15]}}, r_count}) + $signed({4'd0, prod});
        end else begin
            sum = $signed({{2{r_count[15]}}, r_count}) - $signed({4'd0, prod});
        end
        if (sum > max_ext) begin
            det_val = i_cfg.wrap_enable ? i_cfg.min_value : i_cfg.max_value;
        end else if (sum < min_ext) begin
            det_val = i_cfg.wrap_enable ? i_cfg.max_value : i_cfg.min_value;
        end else begin
            det_val = sum[15:0];
        end
    end

    // bound write clamps up to min, then down to max
    always_comb begin
        lo        = i_bound_wr.min_we ? i_bound_wr.bound : i_cfg.min_value;
        hi        = i_bound_wr.max_we ? i_bound_wr.bound : i_cfg.max_value;
        clamp_lo  = (r_count < lo) ? lo : r_count;
        clamp_val = (clamp_lo > hi) ? hi : clamp_lo;
    end

    always_comb begin
        if (i_en && i_detent.fire) begin
            n_count = det_val;
        end else if (i_bound_wr.min_we || i_bound_wr.max_we) begin
            n_count = clamp_val;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        o_value = i_detent.fire ? det_val : r_count;
        if (i_detent.fire && (det_val != r_count)) begin
            o_rot_event = i_detent.up ? rea_pkg::ROT_INC : rea_pkg::ROT_DEC;
        end else begin
            o_rot_event = rea_pkg::ROT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= 16'sd0;
            r_last_detent <= 32'd0;
        end else begin
            r_count <= n_count;
            if (i_en && i_detent.fire) begin
                r_last_detent <= i_now_ms;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rea_button.sv =====
// rea_button: push switch debounce and press start / end events
// depends on rea_pkg
`default_nettype none

module rea_button (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_switch_level,
    input  wire logic [31:0]    i_now_ms,
    output rea_pkg::t_btn_event o_button_event
);

    logic        r_raw;
    logic        n_raw;
    logic [31:0] r_change_time;
    logic [31:0] n_change_time;
    logic        r_deb;
    logic        n_deb;
    logic        r_held;
    logic        n_held;
    logic [31:0] elapsed;

    always_comb begin
        n_raw          = r_raw;
        n_change_time  = r_change_time;
        n_deb          = r_deb;
        n_held         = r_held;
        o_button_event = rea_pkg::BTN_NONE;
        elapsed        = i_now_ms - r_change_time;
        if (i_switch_level != r_raw) begin
            n_raw         = i_switch_level;
            n_change_time = i_now_ms;
        end else if ((i_switch_level != r_deb) && (elapsed > rea_pkg::DEBOUNCE_TIME_MS)) begin
            n_deb = i_switch_level;
            if (!r_held && !i_switch_level) begin
                n_held         = 1'b1;
                o_button_event = rea_pkg::BTN_START;
            end else if (r_held && i_switch_level) begin
                n_held         = 1'b0;
                o_button_event = rea_pkg::BTN_END;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b1;
            r_change_time <= 32'd0;
            r_deb         <= 1'b1;
            r_held        <= 1'b0;
        end else if (i_en) begin
            r_raw         <= n_raw;
            r_change_time <= n_change_time;
            r_deb         <= n_deb;
            r_held        <= n_held;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rotary_encoder_with_accel_top.sv =====
// path: an accepted item is in the input register after its edge; its result then passes
// one logic pass into the result register, from which it is offered on the master side
// throughput: one item per cycle while the master side is not stalling
// the result register takes a new result whenever the old one is taken or empty
// reset: synchronous active-low i_rst_n clears all state but the data registers, no sweep
// rotary_encoder_with_accel_top: top level, stream handshake and pipeline registers
// depends on rea_pkg, rea_cfg_regs, rea_quad_dec, rea_value, rea_button
`default_nettype none

module rotary_encoder_with_accel_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // quad_a, quad_b, switch_level, now_ms[31:0], zero pad
    input  wire logic [rea_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // rot_event[1:0], button_event[1:0], value[15:0], zero pad
    output logic [rea_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [rea_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rea_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic                               r_in_valid;
    rea_pkg::t_sample                   r_in_data;
    rea_pkg::t_sample                   in_sample;
    logic                               r_out_valid;
    logic [rea_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic                               advance;
    logic                               step_en;
    rea_pkg::t_cfg                      cfg;
    rea_pkg::t_bound_wr                 bound_wr;
    rea_pkg::t_detent                   detent;
    rea_pkg::t_rot_event                rot_event;
    rea_pkg::t_btn_event                button_event;
    logic signed [15:0]                 value;

    always_comb begin
        in_sample.quad_a       = s_axis_tdata[0];
        in_sample.quad_b       = s_axis_tdata[1];
        in_sample.switch_level = s_axis_tdata[2];
        in_sample.now_ms       = s_axis_tdata[34:3];
    end

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign step_en       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= in_sample;
        end
    end

    rea_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_idx      (i_cfg_idx),
        .i_wdata    (i_cfg_wdata),
        .o_cfg      (cfg),
        .o_bound_wr (bound_wr)
    );

    rea_quad_dec u_quad_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_quad_a (r_in_data.quad_a),
        .i_quad_b (r_in_data.quad_b),
        .o_detent (detent)
    );

    rea_value u_value (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (step_en),
        .i_detent    (detent),
        .i_now_ms    (r_in_data.now_ms),
        .i_cfg       (cfg),
        .i_bound_wr  (bound_wr),
        .o_rot_event (rot_event),
        .o_value     (value)
    );

    rea_button u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (step_en),
        .i_switch_level (r_in_data.switch_level),
        .i_now_ms       (r_in_data.now_ms),
        .o_button_event (button_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out_data <= {4'd0, value, button_event, rot_event};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/rea_checker.sv =====
// rea_checker: port-level assertions for the rotary encoder top level
// depends on rea_pkg; bound to rotary_encoder_with_accel_top
`default_nettype none

module rea_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [rea_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [rea_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic r_held;
    logic out_accept;
    logic in_accept;

    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign in_accept  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

    // button state as seen from delivered items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (out_accept && (m_axis_tdata[3:2] == rea_pkg::BTN_START)) begin
            r_held <= 1'b1;
        end else if (out_accept && (m_axis_tdata[3:2] == rea_pkg::BTN_END)) begin
            r_held <= 1'b0;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed or dropped");

    a_event_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[3:2] != 2'd3))
        else $error("undefined event code");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready && !in_accept |-> s_axis_tready)
        else $error("input stalled while output side is ready");

    a_button_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept |-> ((m_axis_tdata[3:2] != rea_pkg::BTN_START) || !r_held) &&
                       ((m_axis_tdata[3:2] != rea_pkg::BTN_END) || r_held))
        else $error("press events out of order");

endmodule

bind rotary_encoder_with_accel_top rea_checker u_rea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for rotary_encoder_with_accel_top: directed and random encoder samples
// checked item by item against a scoreboard that predicts each result
// depends on rea_pkg and the rtl under rtl/core
`timescale 1ns / 100ps

module testbench;

    localparam int ITEMS_PER_PHASE = 180;

    typedef struct {
        rea_pkg::t_rot_event rot;
        rea_pkg::t_btn_event btn;
        logic signed [15:0]  value;
    } t_knob_report;

    class t_knob_scoreboard;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic               wrap_on;
        logic [9:0]         step_size;
        logic [15:0]        medium_ms;
        logic [15:0]        fast_ms;
        logic [3:0]         medium_mult;
        logic [3:0]         quick_factor;
        logic [1:0]         last_phase;
        int                 step_accum;
        logic signed [15:0] knob_value;
        logic [31:0]        last_detent_ms;
        logic               raw_sw;
        logic               stable_sw;
        logic               held;
        logic [31:0]        sw_change_ms;
        t_knob_report       expected_reports[$];
        int                 errors;
        int                 checked;

        function new();
            min_value      = 16'sd0;
            max_value      = 16'sd127;
            wrap_on        = 1'b0;
            step_size      = 10'd1;
            medium_ms      = 16'd100;
            fast_ms        = 16'd40;
            medium_mult    = 4'd2;
            quick_factor   = 4'd3;
            last_phase     = 2'd3;
            step_accum     = 0;
            knob_value     = 16'sd0;
            last_detent_ms = 32'd0;
            raw_sw         = 1'b1;
            stable_sw      = 1'b1;
            held           = 1'b0;
            sw_change_ms   = 32'd0;
            errors         = 0;
            checked        = 0;
        endfunction

        task report_mismatch(input string what, input int got, input int want);
            if (errors < 40) begin
                $display("mismatch at result %0d: %s got %0d expected %0d",
                         checked, what, got, want);
            end
            errors++;
        endtask

        function void write_reg(input rea_pkg::t_reg_idx idx, input logic [15:0] wdata);
            case (idx)
                rea_pkg::REG_MIN_VALUE:   min_value = wdata;
                rea_pkg::REG_MAX_VALUE:   max_value = wdata;
                rea_pkg::REG_WRAP_ENABLE: wrap_on = wdata[0];
                rea_pkg::REG_STEP_SIZE:
                    step_size = (wdata[9:0] == 10'd0) ? 10'd1 : wdata[9:0];
                rea_pkg::REG_MEDIUM_MS:   medium_ms = (wdata == 16'd0) ? 16'd1 : wdata;
                rea_pkg::REG_FAST_MS:     fast_ms = (wdata == 16'd0) ? 16'd1 : wdata;
                rea_pkg::REG_MEDIUM_MULT:
                    medium_mult = (wdata[3:0] == 4'd0) ? 4'd2 : wdata[3:0];
                rea_pkg::REG_FAST_MULT:
                    quick_factor = (wdata[3:0] == 4'd0) ? 4'd4 : wdata[3:0];
                default: ;
            endcase
            if (idx == rea_pkg::REG_MIN_VALUE || idx == rea_pkg::REG_MAX_VALUE) begin
                if (knob_value < min_value) knob_value = min_value;
                if (knob_value > max_value) knob_value = max_value;
            end
        endfunction

        function void note_sample(input logic [rea_pkg::IN_TDATA_W-1:0] item);
            logic [1:0]   cur;
            logic         sw;
            logic [31:0]  now;
            logic [1:0]   pos_last;
            logic [1:0]   pos_cur;
            logic [1:0]   span;
            logic [31:0]  gap;
            int           delta;
            int           full;
            int           mult;
            int           old_i;
            int           next_i;
            int           step_i;
            t_knob_report r;
            cur   = {item[0], item[1]};
            sw    = item[2];
            now   = item[34:3];
            r.rot = rea_pkg::ROT_NONE;
            r.btn = rea_pkg::BTN_NONE;
            if (cur != last_phase) begin
                // position on the quadrature ring, skipped phase counts double
                pos_last = {last_phase[1], ^last_phase};
                pos_cur  = {cur[1], ^cur};
                span     = pos_cur - pos_last;
                if (span == 2'd1) begin
                    delta = 1;
                end else if (span == 2'd3) begin
                    delta = -1;
                end else begin
                    delta = (pos_cur > pos_last) ? 2 : -2;
                end
                step_accum += delta;
                full = step_accum / 4;
                if (full != 0) begin
                    gap  = (last_detent_ms == 32'd0) ? 32'd0 : now - last_detent_ms;
                    mult = 1;
                    if (gap != 32'd0) begin
                        if (gap <= {16'd0, fast_ms}) begin
                            mult = quick_factor;
                        end else if (gap <= {16'd0, medium_ms}) begin
                            mult = medium_mult;
                        end
                    end
                    old_i  = knob_value;
                    step_i = step_size;
                    next_i = old_i + full * step_i * mult;
                    if (next_i > max_value) begin
                        next_i = wrap_on ? min_value : max_value;
                    end else if (next_i < min_value) begin
                        next_i = wrap_on ? max_value : min_value;
                    end
                    if (next_i != old_i) begin
                        if (full > 0) r.rot = rea_pkg::ROT_INC;
                        else r.rot = rea_pkg::ROT_DEC;
                    end
                    knob_value     = next_i[15:0];
                    step_accum    -= full * 4;
                    last_detent_ms = now;
                end
                last_phase = cur;
            end
            if (sw != raw_sw) begin
                raw_sw       = sw;
                sw_change_ms = now;
            end else if (sw != stable_sw &&
                         (now - sw_change_ms) > rea_pkg::DEBOUNCE_TIME_MS) begin
                stable_sw = sw;
                if (!held && !sw) begin
                    held  = 1'b1;
                    r.btn = rea_pkg::BTN_START;
                end else if (held && sw) begin
                    held  = 1'b0;
                    r.btn = rea_pkg::BTN_END;
                end
            end
            r.value = knob_value;
            expected_reports.push_back(r);
        endfunction

        task check_report(input logic [rea_pkg::OUT_TDATA_W-1:0] item);
            t_knob_report e;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result, value", $signed(item[19:4]), 0);
                return;
            end
            e = expected_reports.pop_front();
            if (item[1:0] !== e.rot) report_mismatch("rot_event", item[1:0], e.rot);
            if (item[3:2] !== e.btn) report_mismatch("button_event", item[3:2], e.btn);
            if (item[19:4] !== e.value) begin
                report_mismatch("value", $signed(item[19:4]), e.value);
            end
            if (item[23:20] !== 4'd0) report_mismatch("pad bits", item[23:20], 0);
            checked++;
        endtask
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // quad_a, quad_b, switch_level, now_ms[31:0], zero pad
    logic [rea_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // rot_event[1:0], button_event[1:0], value[15:0], zero pad
    logic [rea_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_we;
    logic [rea_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [rea_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;

    t_knob_scoreboard sb = new();

    int          send_idle_pct;
    int          stall_pct;
    logic [1:0]  enc_phase;
    logic        sw_level;
    logic [31:0] now_ms;
    int          turn_dir;

    rotary_encoder_with_accel_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
        end
    end

    task send_sample(input logic [1:0] ph, input logic sw, input logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, t, sw, ph[0], ph[1]};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // walk the ring by delta positions per item, n items at time t
    task quarter_turns(input int n, input int delta, input logic [31:0] t);
        logic [1:0] pos;
        for (int i = 0; i < n; i++) begin
            pos       = 2'({enc_phase[1], ^enc_phase} + delta);
            enc_phase = {pos[1], ^pos};
            send_sample(enc_phase, sw_level, t);
        end
    endtask

    task cfg_write(input rea_pkg::t_reg_idx idx, input logic [15:0] wdata);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = wdata;
        sb.write_reg(idx, wdata);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task drain_results();
        for (int n = 0; n < 4000 && sb.expected_reports.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int          r;
        logic [15:0] lo;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        enc_phase     = rea_pkg::PHASE_IDLE;
        sw_level      = 1'b1;
        now_ms        = 32'd0;
        turn_dir      = 1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // detent at time zero, first detent, zero interval, fast, then a skip back at medium
        send_sample(enc_phase, sw_level, 32'd0);
        quarter_turns(4, 1, 32'd0);
        quarter_turns(4, 1, 32'd10);
        quarter_turns(4, 1, 32'd10);
        quarter_turns(4, 1, 32'd30);
        quarter_turns(1, -2, 32'd100);
        quarter_turns(2, -1, 32'd100);
        // press held just at and past the debounce time, then release
        sw_level = 1'b0;
        send_sample(enc_phase, sw_level, 32'd101);
        send_sample(enc_phase, sw_level, 32'd106);
        send_sample(enc_phase, sw_level, 32'd107);
        sw_level = 1'b1;
        send_sample(enc_phase, sw_level, 32'd108);
        send_sample(enc_phase, sw_level, 32'd120);
        now_ms = 32'd120;

        for (int k = 0; k < 8; k++) begin
            s_axis_tvalid = 1'b0;
            drain_results();
            case (k)
                1: begin
                    cfg_write(rea_pkg::REG_MIN_VALUE, 16'h8000);
                    cfg_write(rea_pkg::REG_MAX_VALUE, 16'h7fff);
                    cfg_write(rea_pkg::REG_WRAP_ENABLE, 16'd1);
                    cfg_write(rea_pkg::REG_STEP_SIZE, 16'd1023);
                    cfg_write(rea_pkg::REG_MEDIUM_MS, 16'hffff);
                    cfg_write(rea_pkg::REG_FAST_MS, 16'hffff);
                    cfg_write(rea_pkg::REG_MEDIUM_MULT, 16'd15);
                    cfg_write(rea_pkg::REG_FAST_MULT, 16'd15);
                end
                2: begin
                    cfg_write(rea_pkg::REG_MIN_VALUE, -16'sd5);
                    cfg_write(rea_pkg::REG_MAX_VALUE, 16'sd5);
                    cfg_write(rea_pkg::REG_WRAP_ENABLE, 16'd0);
                    cfg_write(rea_pkg::REG_STEP_SIZE, 16'd0);
                    cfg_write(rea_pkg::REG_MEDIUM_MS, 16'd0);
                    cfg_write(rea_pkg::REG_FAST_MS, 16'd0);
                    cfg_write(rea_pkg::REG_MEDIUM_MULT, 16'd0);
                    cfg_write(rea_pkg::REG_FAST_MULT, 16'd0);
                end
                3: begin
                    // bounds crossed over
                    cfg_write(rea_pkg::REG_MIN_VALUE, 16'sd10);
                    cfg_write(rea_pkg::REG_MAX_VALUE, -16'sd10);
                    cfg_write(rea_pkg::REG_WRAP_ENABLE, 16'd1);
                    cfg_write(rea_pkg::REG_STEP_SIZE, 16'd3);
                    cfg_write(rea_pkg::REG_MEDIUM_MS, 16'd100);
                    cfg_write(rea_pkg::REG_FAST_MS, 16'd40);
                end
                default: begin
                    if (k > 3) begin
                        lo = 16'($urandom_range(0, 400) - 200);
                        cfg_write(rea_pkg::REG_MIN_VALUE, lo);
                        if ($urandom_range(0, 7) == 0) begin
                            cfg_write(rea_pkg::REG_MAX_VALUE, 16'(lo - 20));
                        end else begin
                            cfg_write(rea_pkg::REG_MAX_VALUE,
                                      16'(lo + $urandom_range(0, 300)));
                        end
                        cfg_write(rea_pkg::REG_WRAP_ENABLE, 16'($urandom_range(0, 65535)));
                        if ($urandom_range(0, 3) == 0) begin
                            cfg_write(rea_pkg::REG_STEP_SIZE, 16'($urandom_range(0, 65535)));
                        end else begin
                            cfg_write(rea_pkg::REG_STEP_SIZE, 16'($urandom_range(0, 12)));
                        end
                        cfg_write(rea_pkg::REG_MEDIUM_MS, 16'($urandom_range(0, 150)));
                        cfg_write(rea_pkg::REG_FAST_MS, 16'($urandom_range(0, 60)));
                        cfg_write(rea_pkg::REG_MEDIUM_MULT, 16'($urandom_range(0, 255)));
                        cfg_write(rea_pkg::REG_FAST_MULT, 16'($urandom_range(0, 255)));
                    end
                end
            endcase
            if (k == 5) now_ms = 32'hffff_ff00;
            case (k % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    now_ms = $urandom;
                end else if (r >= 18 && r < 88) begin
                    now_ms += $urandom_range(1, 60);
                end else if (r >= 88) begin
                    now_ms += $urandom_range(61, 400);
                end
                if ($urandom_range(0, 99) < 10) sw_level = ~sw_level;
                if ($urandom_range(0, 9) == 0) turn_dir = -turn_dir;
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    quarter_turns(1, turn_dir, now_ms);
                end else if (r < 84) begin
                    quarter_turns(1, 2 * turn_dir, now_ms);
                end else begin
                    // noise: held or random phase
                    if (r >= 92) enc_phase = 2'($urandom_range(0, 3));
                    send_sample(enc_phase, sw_level, now_ms);
                end
            end
        end

        s_axis_tvalid = 1'b0;
        drain_results();
        if (sb.expected_reports.size() != 0) begin
            sb.report_mismatch("results left waiting", 0, sb.expected_reports.size());
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/rea_pkg.sv
rtl/core/rea_cfg_regs.sv
rtl/core/rea_quad_dec.sv
rtl/core/rea_value.sv
rtl/core/rea_button.sv
rtl/core/rotary_encoder_with_accel_top.sv
rtl/core/rea_checker.sv
test/testbench.sv
